// ===== rtl/cst_pkg.sv =====
`default_nettype none

package cst_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int QUOT_BITS = 8;
    localparam int CNT_W     = $clog2(QUOT_BITS);
    localparam int NUM_W     = 2 * SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] LOW_RESET  = 8'hFF;
    localparam logic [SAMPLE_W-1:0] HIGH_RESET = 8'h00;

    // pass codes carried in the func field
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_MAP     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // measured bounds of the current frame
    typedef struct packed {
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic                flat;
    } t_range;

    // divider status toward the control
    typedef struct packed {
        logic                 busy;
        logic                 last;
        logic [QUOT_BITS-1:0] quot;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/cst_if.sv =====
`default_nettype none

interface cst_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       start_frame;
    logic [7:0] sample;

    modport source (output valid, output func, output start_frame, output sample,
                    input ready);
    modport sink   (input valid, input func, input start_frame, input sample,
                    output ready);
endinterface

interface cst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] stretched;
    logic       flat_frame;

    modport source (output valid, output stretched, output flat_frame, input ready);
    modport sink   (input valid, input stretched, input flat_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/cst_range.sv =====
`default_nettype none

module cst_range (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_update,
    input  wire logic                         i_restart,
    input  wire logic [cst_pkg::SAMPLE_W-1:0] i_sample,
    output cst_pkg::t_range                   o_range
);

    logic [cst_pkg::SAMPLE_W-1:0] r_lo;
    logic [cst_pkg::SAMPLE_W-1:0] r_hi;
    logic [cst_pkg::SAMPLE_W-1:0] n_lo;
    logic [cst_pkg::SAMPLE_W-1:0] n_hi;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_update) begin
            if (i_restart) begin
                n_lo = i_sample;
                n_hi = i_sample;
            end else begin
                if (i_sample < r_lo) begin
                    n_lo = i_sample;
                end
                if (i_sample > r_hi) begin
                    n_hi = i_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= cst_pkg::LOW_RESET;
            r_hi <= cst_pkg::HIGH_RESET;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // inverted bounds (nothing measured) count as flat
    assign o_range.lo   = r_lo;
    assign o_range.hi   = r_hi;
    assign o_range.flat = (r_hi <= r_lo);

endmodule

`default_nettype wire

// ===== rtl/cst_div.sv =====
`default_nettype none

module cst_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cst_pkg::NUM_W-1:0]     i_num,
    input  wire logic [cst_pkg::SAMPLE_W-1:0]  i_den,
    output cst_pkg::t_div_stat                 o_stat
);

    localparam logic [cst_pkg::CNT_W-1:0] LAST_CNT = cst_pkg::CNT_W'(cst_pkg::QUOT_BITS - 1);

    logic                           r_busy;
    logic [cst_pkg::CNT_W-1:0]      r_cnt;
    logic [cst_pkg::SAMPLE_W-1:0]   r_rem;
    logic [cst_pkg::QUOT_BITS-1:0]  r_sh;
    logic [cst_pkg::SAMPLE_W-1:0]   r_den;
    logic [cst_pkg::SAMPLE_W:0]     trial;
    logic [cst_pkg::SAMPLE_W:0]     diff;
    logic                           qbit;
    logic [cst_pkg::SAMPLE_W-1:0]   n_rem;

    // restoring step: bring down one dividend bit, try one subtract
    always_comb begin
        trial = {r_rem, r_sh[cst_pkg::QUOT_BITS-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? diff[cst_pkg::SAMPLE_W-1:0] : trial[cst_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend low bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[cst_pkg::NUM_W-1:cst_pkg::SAMPLE_W];
            r_sh  <= i_num[cst_pkg::QUOT_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[cst_pkg::QUOT_BITS-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.last = r_busy && (r_cnt == LAST_CNT);
    assign o_stat.quot = {r_sh[cst_pkg::QUOT_BITS-2:0], qbit};

endmodule

`default_nettype wire

// ===== rtl/contrast_stretch.sv =====
// contrast_stretch: two-pass min/max linear contrast stretch of 8-bit samples
//
// i_in carries one sample word: func, start_frame, sample. func low is a
// measure word: it folds the sample into the running minimum and maximum
// (start_frame restarts both at that sample) and gives no output word.
// func high is a map word: it gives one output word on o_out with
// stretched = (p - min) * 255 / (max - min), p clamped to [min, max].
// when max is not above min the sample passes through and flat_frame is set.
//
// the input stays ready after a measure word and after a flat map word
// that finds the output free; a stretched map word holds it off while the
// bit-serial restoring divider runs, one quotient bit per cycle.
// a stretched result enters the output register with the last quotient
// bit, a flat result at its own accept edge, when the output is free.
//
// the output register decouples the two sides: a new word is taken while a
// finished one waits. when o_out stalls, a result that cannot enter the
// output register is parked and the input holds off until it moves.
// reset restores min to 255 and max to 0 and empties the output.
`default_nettype none

module contrast_stretch (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cst_in_if.sink     i_in,
    cst_out_if.source  o_out
);

    cst_pkg::t_state    r_state;
    cst_pkg::t_state    n_state;
    cst_pkg::t_range    range;
    cst_pkg::t_div_stat div_stat;

    logic                          in_fire;
    logic                          measure_fire;
    logic                          map_fire;
    logic                          out_free;
    logic [cst_pkg::SAMPLE_W-1:0]  clamped;
    logic [cst_pkg::SAMPLE_W-1:0]  delta;
    logic [cst_pkg::SAMPLE_W-1:0]  span;
    logic [cst_pkg::NUM_W-1:0]     num;
    logic                          div_start;

    // output register and parked result
    logic                          r_out_valid;
    logic [cst_pkg::SAMPLE_W-1:0]  r_out_data;
    logic                          r_out_flat;
    logic [cst_pkg::SAMPLE_W-1:0]  r_hold_data;
    logic                          r_hold_flat;
    logic                          out_load;
    logic [cst_pkg::SAMPLE_W-1:0]  out_data;
    logic                          out_flat;
    logic                          hold_load;
    logic [cst_pkg::SAMPLE_W-1:0]  hold_data;
    logic                          hold_flat;

    assign i_in.ready   = (r_state == cst_pkg::ST_IDLE);
    assign in_fire      = i_in.valid && i_in.ready;
    assign measure_fire = in_fire && (i_in.func == cst_pkg::FUNC_MEASURE);
    assign map_fire     = in_fire && (i_in.func == cst_pkg::FUNC_MAP);
    assign out_free     = !r_out_valid || o_out.ready;

    cst_range u_range (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (measure_fire),
        .i_restart (i_in.start_frame),
        .i_sample  (i_in.sample),
        .o_range   (range)
    );

    // clamp into the measured range, numerator is delta * 255
    always_comb begin
        if (i_in.sample < range.lo) begin
            clamped = range.lo;
        end else if (i_in.sample > range.hi) begin
            clamped = range.hi;
        end else begin
            clamped = i_in.sample;
        end
        delta = clamped - range.lo;
        span  = range.hi - range.lo;
        num   = {delta, {cst_pkg::SAMPLE_W{1'b0}}} - {{cst_pkg::SAMPLE_W{1'b0}}, delta};
    end

    assign div_start = map_fire && !range.flat;

    cst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (span),
        .o_stat  (div_stat)
    );

    // control: idle takes words, div waits on quotient bits, done parks a result
    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        out_data  = r_hold_data;
        out_flat  = r_hold_flat;
        hold_load = 1'b0;
        hold_data = i_in.sample;
        hold_flat = 1'b1;
        unique case (r_state)
            cst_pkg::ST_IDLE: begin
                if (map_fire) begin
                    if (range.flat) begin
                        out_data = i_in.sample;
                        out_flat = 1'b1;
                        if (out_free) begin
                            out_load = 1'b1;
                        end else begin
                            hold_load = 1'b1;
                            n_state   = cst_pkg::ST_DONE;
                        end
                    end else begin
                        n_state = cst_pkg::ST_DIV;
                    end
                end
            end
            cst_pkg::ST_DIV: begin
                if (div_stat.last) begin
                    out_data  = div_stat.quot;
                    out_flat  = 1'b0;
                    hold_data = div_stat.quot;
                    hold_flat = 1'b0;
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = cst_pkg::ST_IDLE;
                    end else begin
                        hold_load = 1'b1;
                        n_state   = cst_pkg::ST_DONE;
                    end
                end
            end
            cst_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = cst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_data;
            r_out_flat <= out_flat;
        end
        if (hold_load) begin
            r_hold_data <= hold_data;
            r_hold_flat <= hold_flat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.stretched  = r_out_data;
    assign o_out.flat_frame = r_out_flat;

    // the last quotient bit always traces back to a matching divider start
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.last |-> $past(div_start, cst_pkg::QUOT_BITS))
        else $error("divider finished off its eight-step schedule");

    // the divider only runs while the control waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == cst_pkg::ST_DIV))
        else $error("divider busy outside the divide state");

    // a flat map word with a free output shows up as a flat word next cycle
    a_flat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (map_fire && range.flat && out_free) |=> (r_out_valid && r_out_flat))
        else $error("flat map word not delivered");

    // a stretched word never carries the flat flag
    a_div_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.last && out_free) |=> (r_out_valid && !r_out_flat))
        else $error("stretched word lost or flagged flat");

endmodule

`default_nettype wire

// ===== tb/contrast_stretch_tb.sv =====
`timescale 1ns / 100ps

module contrast_stretch_tb;

    localparam int FULL_SCALE     = 255;
    localparam int RANDOM_WORDS   = 1950;
    // long receiver hold-off, so the output register and the parked result fill up
    localparam int HOLD_CYCLES    = 400;
    // no correct run goes this long without a word moving on either side
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time after the drain, so a stray extra result still reaches the checker
    localparam int TAIL_CYCLES    = 20;

    // one stretched pixel as it leaves the block
    typedef struct packed {
        logic [cst_pkg::SAMPLE_W-1:0] stretched;
        logic                         flat_frame;
    } t_pixel;

    // keeps its own running min / max and the queue of pixels still owed
    class stretch_checker;
        logic [cst_pkg::SAMPLE_W-1:0] frame_min;
        logic [cst_pkg::SAMPLE_W-1:0] frame_max;
        t_pixel                       pending_pixels[$];
        int unsigned                  words_in;
        int unsigned                  pixels_out;
        int unsigned                  flat_out;
        int unsigned                  errors;

        function new();
            frame_min = cst_pkg::LOW_RESET;
            frame_max = cst_pkg::HIGH_RESET;
        endfunction

        // called for every word taken on the input
        function void note_sample(logic func, logic start, logic [cst_pkg::SAMPLE_W-1:0] p);
            t_pixel      px;
            int unsigned clamped;
            words_in++;
            if (func == cst_pkg::FUNC_MEASURE) begin
                if (start) begin
                    frame_min = p;
                    frame_max = p;
                end else begin
                    if (p < frame_min) frame_min = p;
                    if (p > frame_max) frame_max = p;
                end
                return;
            end
            // empty or inverted bounds count as a flat frame
            if (frame_max <= frame_min) begin
                px.stretched  = p;
                px.flat_frame = 1'b1;
            end else begin
                clamped = p;
                if (clamped < frame_min) clamped = frame_min;
                if (clamped > frame_max) clamped = frame_max;
                px.stretched  = cst_pkg::SAMPLE_W'(((clamped - frame_min) * FULL_SCALE) /
                                                   (frame_max - frame_min));
                px.flat_frame = 1'b0;
            end
            pending_pixels.push_back(px);
        endfunction

        // called for every word taken on the output
        function void check_result(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: stretched %0d flat_frame %0b",
                       got.stretched, got.flat_frame);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_out++;
            if (want.flat_frame) flat_out++;
            if (got.stretched !== want.stretched) begin
                $error("stretched mismatch: expected %0d, got %0d",
                       want.stretched, got.stretched);
                errors++;
            end
            if (got.flat_frame !== want.flat_frame) begin
                $error("flat_frame mismatch: expected %0b, got %0b",
                       want.flat_frame, got.flat_frame);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cst_in_if  in_ch();
    cst_out_if out_ch();

    stretch_checker sb = new();

    // set by the stimulus: no random gaps on either side for this stretch
    bit steady;
    // set by the stimulus, taken and cleared by the receiver
    bit hold_off_req;
    int unsigned idle_cycles;

    contrast_stretch dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one word, hold it until taken, then hand it to the checker
    task automatic send_word(logic func, logic start, logic [cst_pkg::SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.start_frame <= start;
        in_ch.sample      <= s;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_sample(func, start, s);
    endtask

    // result side: checks every word taken, stalls at random, honors hold-off
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        logic        take;
        t_pixel      got;
        stall_left = 0;
        run_left   = 0;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                got.stretched  = out_ch.stretched;
                got.flat_frame = out_ch.flat_frame;
                sb.check_result(got);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            // new run of ready cycles, sometimes led by a stall
            if (stall_left == 0 && run_left == 0 && !steady) begin
                run_left = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                take = 1'b0;
                stall_left--;
            end else begin
                take = 1'b1;
                if (run_left > 0) run_left--;
            end
            out_ch.ready <= take;
        end
    end

    // watchdog: counts cycles with no word moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still owed",
                     WATCHDOG_LIMIT, sb.pending_pixels.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned target;
        int unsigned frames;
        int unsigned lo_b;
        int unsigned hi_b;
        int unsigned n_meas;
        int unsigned n_map;
        logic        st;
        logic [cst_pkg::SAMPLE_W-1:0] s;

        frames = 0;
        steady = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= cst_pkg::FUNC_MEASURE;
        in_ch.start_frame <= 1'b0;
        in_ch.sample      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight after reset min is 255 and max 0: inverted bounds, pass-through
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd0);
        send_word(cst_pkg::FUNC_MAP, 1'b1, 8'd255);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd128);

        // first measure word without a start flag folds into the reset bounds
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd100);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd100);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd7);

        // ordinary frame 10..200, samples inside, on and beyond the bounds
        send_word(cst_pkg::FUNC_MEASURE, 1'b1, 8'd10);
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd200);
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd50);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd10);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd200);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd0);
        send_word(cst_pkg::FUNC_MAP, 1'b1, 8'd255);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd105);

        // full-scale frame
        send_word(cst_pkg::FUNC_MEASURE, 1'b1, 8'd0);
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd255);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd1);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd254);

        // single-sample frame is flat, even for a sample far off
        send_word(cst_pkg::FUNC_MEASURE, 1'b1, 8'd77);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd200);

        // narrowest stretch: a range of one code
        send_word(cst_pkg::FUNC_MEASURE, 1'b1, 8'd5);
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd6);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd6);
        send_word(cst_pkg::FUNC_MAP, 1'b0, 8'd5);

        // back-pressure: receiver holds off while map words keep coming
        steady = 1'b1;
        send_word(cst_pkg::FUNC_MEASURE, 1'b1, 8'd3);
        send_word(cst_pkg::FUNC_MEASURE, 1'b0, 8'd250);
        hold_off_req = 1'b1;
        repeat (12) send_word(cst_pkg::FUNC_MAP, 1'b0, 8'($urandom_range(0, 255)));
        steady = 1'b0;

        // random frames: a measure pass then a map pass, with some noise mixed in
        target = sb.words_in + RANDOM_WORDS;
        while (sb.words_in < target) begin
            frames++;
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: words of any shape in any order
                repeat ($urandom_range(1, 10))
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
            end else begin
                lo_b = $urandom_range(0, 255);
                if ($urandom_range(0, 4) == 0) hi_b = lo_b + $urandom_range(0, 1);
                else hi_b = $urandom_range(lo_b, 255);
                if (hi_b > 255) hi_b = 255;
                n_meas = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                n_map  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(1, 16);
                for (int i = 0; i < n_meas; i++) begin
                    // a frame mostly opens with the start flag, rarely restarts midway
                    st = (i == 0) ? ($urandom_range(0, 9) != 0)
                                  : ($urandom_range(0, 19) == 0);
                    send_word(cst_pkg::FUNC_MEASURE, st, 8'($urandom_range(lo_b, hi_b)));
                end
                for (int i = 0; i < n_map; i++) begin
                    // now and then a sample outside the measured range
                    s = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(lo_b, hi_b));
                    send_word(cst_pkg::FUNC_MAP, 1'($urandom_range(0, 1)), s);
                end
            end
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        // drain: the watchdog catches results that never come
        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d words in (%0d random frames), %0d results checked, %0d flat",
                 sb.words_in, frames, sb.pixels_out, sb.flat_out);
        $display("summary: one %0d-cycle receiver hold-off, random gaps on both sides",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cst_pkg.sv
rtl/cst_if.sv
rtl/cst_range.sv
rtl/cst_div.sv
rtl/contrast_stretch.sv
tb/contrast_stretch_tb.sv
